### rtl/tld_pkg.sv
// Shared types, codes and echo tables for the terminal line discipline.
`timescale 1ns / 1ps
`default_nettype none

package tld_pkg;

    localparam int BUF_DEPTH_DEFAULT = 256;
    localparam int APB_ADDR_W        = 3;
    localparam int APB_DATA_W        = 32;

    // Register index, taken from paddr[2].
    localparam logic REG_RAW_MODE = 1'b0;

    localparam logic [2:0] OP_MASTER_WRITE = 3'd0;
    localparam logic [2:0] OP_SLAVE_WRITE  = 3'd1;
    localparam logic [2:0] OP_MASTER_READ  = 3'd2;
    localparam logic [2:0] OP_SLAVE_READ   = 3'd3;
    localparam logic [2:0] OP_TAKE_INTR    = 3'd4;

    localparam logic [7:0] CHAR_CR    = 8'h0d;
    localparam logic [7:0] CHAR_LF    = 8'h0a;
    localparam logic [7:0] CHAR_DEL   = 8'h7f;
    localparam logic [7:0] CHAR_BS    = 8'h08;
    localparam logic [7:0] CHAR_ETX   = 8'h03;
    localparam logic [7:0] CHAR_EOT   = 8'h04;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_CARET = 8'h5e;
    localparam logic [7:0] CHAR_C     = 8'h43;

    localparam logic [1:0] ECHO_SINGLE = 2'd0;
    localparam logic [1:0] ECHO_CRLF   = 2'd1;
    localparam logic [1:0] ECHO_ERASE  = 2'd2;
    localparam logic [1:0] ECHO_INTR   = 2'd3;

    typedef struct packed {
        logic [2:0] op;
        logic [7:0] byte_in;
    } cmd_t;

    typedef struct packed {
        logic [7:0] byte_out;
        logic       read_valid;
        logic       end_of_file;
        logic       interrupt_pending;
    } rsp_t;

    // Index of the last byte of an echo string.
    function automatic logic [1:0] echo_last(input logic [1:0] kind);
        logic [1:0] last;
        case (kind)
            ECHO_SINGLE: last = 2'd0;
            ECHO_CRLF:   last = 2'd1;
            ECHO_ERASE:  last = 2'd2;
            ECHO_INTR:   last = 2'd3;
            default:     last = 2'd0;
        endcase
        return last;
    endfunction

    function automatic logic [7:0] echo_byte(input logic [1:0] kind, input logic [1:0] idx,
                                             input logic [7:0] ch);
        logic [7:0] b;
        b = ch;
        case (kind)
            ECHO_SINGLE: b = ch;
            ECHO_CRLF:   b = (idx == 2'd0) ? CHAR_CR : CHAR_LF;
            ECHO_ERASE:  b = (idx == 2'd1) ? CHAR_SPACE : CHAR_BS;
            ECHO_INTR:
            begin
                case (idx)
                    2'd0:    b = CHAR_CARET;
                    2'd1:    b = CHAR_C;
                    2'd2:    b = CHAR_CR;
                    default: b = CHAR_LF;
                endcase
            end
            default:     b = ch;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

### rtl/terminal_line_discipline.sv
// Top level of the terminal line discipline: rings, line buffer and edit sequencer.
//
//   channel   direction   handshake             payload
//   cmd       in          cmd_valid/cmd_ready   tld_pkg::cmd_t (op, byte_in)
//   rsp       out         rsp_valid/rsp_ready   tld_pkg::rsp_t (one per command)
//   apb       in/out      psel/penable/pready   raw_mode at address 0
//
// A command echoes up to 4 bytes, a read waits on the registered memory output,
// and a line flush copies the line into the to-slave ring, then a trailing LF after
// CR or LF. The memory ports move one ring byte per cycle.
// Reset clears pointers, counts and flags; ring and line contents stay unset.
// A stalled result sits in the output register while the next command runs.
`timescale 1ns / 1ps
`default_nettype none

module terminal_line_discipline #(
    parameter int BUF_DEPTH = tld_pkg::BUF_DEPTH_DEFAULT
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cmd_valid,
    output logic                                 cmd_ready,
    input  wire tld_pkg::cmd_t                   cmd,
    output logic                                 rsp_valid,
    input  wire logic                            rsp_ready,
    output tld_pkg::rsp_t                        rsp,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [tld_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [tld_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [tld_pkg::APB_DATA_W-1:0]       prdata,
    output logic                                 pready
);
    import tld_pkg::*;

    localparam int PTR_W       = $clog2(BUF_DEPTH);
    localparam int CNT_W       = $clog2(BUF_DEPTH + 1);
    localparam int MEM_A_DEPTH = 2 * (2 ** PTR_W);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(BUF_DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(BUF_DEPTH - 1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_ECHO   = 3'd1;
    localparam logic [2:0] S_FLUSH  = 3'd2;
    localparam logic [2:0] S_LF     = 3'd3;
    localparam logic [2:0] S_RDWAIT = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] n;
        n = (p == PTR_LAST) ? '0 : p + 1'b1;
        return n;
    endfunction

    // Memory A: the to-slave ring in the lower half, the line buffer in the upper half.
    // Memory B: the to-master ring.
    logic [7:0] mem_a [MEM_A_DEPTH];
    logic [7:0] mem_b [BUF_DEPTH];

    logic             a_we, a_re, b_we, b_re;
    logic [PTR_W:0]   a_waddr, a_raddr;
    logic [PTR_W-1:0] b_waddr, b_raddr;
    logic [7:0]       a_wdata, b_wdata;
    logic [7:0]       a_rdata_reg, b_rdata_reg;

    logic [2:0]       state_reg, state_next;
    logic [PTR_W-1:0] ts_head_reg, ts_head_next, ts_tail_reg, ts_tail_next;
    logic [CNT_W-1:0] ts_count_reg, ts_count_next;
    logic [PTR_W-1:0] tm_head_reg, tm_head_next, tm_tail_reg, tm_tail_next;
    logic [CNT_W-1:0] tm_count_reg, tm_count_next;
    logic [CNT_W-1:0] line_len_reg, line_len_next;
    logic [CNT_W-1:0] fl_idx_reg, fl_idx_next;
    logic             wr_pend_reg, wr_pend_next;
    logic             flush_pend_reg, flush_pend_next;
    logic             lf_pend_reg, lf_pend_next;
    logic             intr_reg, intr_next;
    logic             eof_reg, eof_next;
    logic             raw_reg, raw_next;
    logic             rd_sel_reg, rd_sel_next;
    logic             out_valid_reg, out_valid_next;
    logic [1:0]       echo_kind_reg, echo_kind_next;
    logic [1:0]       echo_idx_reg, echo_idx_next;
    logic [1:0]       echo_last_reg, echo_last_next;
    logic [7:0]       echo_char_reg, echo_char_next;
    rsp_t             res_reg, res_next;
    rsp_t             out_reg, out_next;

    logic             ts_push, tm_push;
    logic [7:0]       ts_push_byte, tm_push_byte;

    assign cmd_ready = (state_reg == S_IDLE);
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;
    assign pready    = 1'b1;
    assign prdata    = (paddr[2] == REG_RAW_MODE) ? {{(APB_DATA_W-1){1'b0}}, raw_reg} : '0;

    always_comb
    begin
        raw_next = raw_reg;
        if (psel && penable && pwrite && paddr[2] == REG_RAW_MODE)
        begin
            raw_next = pwdata[0];
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        ts_head_next    = ts_head_reg;
        ts_tail_next    = ts_tail_reg;
        ts_count_next   = ts_count_reg;
        tm_head_next    = tm_head_reg;
        tm_tail_next    = tm_tail_reg;
        tm_count_next   = tm_count_reg;
        line_len_next   = line_len_reg;
        fl_idx_next     = fl_idx_reg;
        wr_pend_next    = wr_pend_reg;
        flush_pend_next = flush_pend_reg;
        lf_pend_next    = lf_pend_reg;
        intr_next       = intr_reg;
        eof_next        = eof_reg;
        rd_sel_next     = rd_sel_reg;
        echo_kind_next  = echo_kind_reg;
        echo_idx_next   = echo_idx_reg;
        echo_last_next  = echo_last_reg;
        echo_char_next  = echo_char_reg;
        res_next        = res_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg & ~rsp_ready;

        a_we = 1'b0; a_waddr = '0; a_wdata = '0;
        a_re = 1'b0; a_raddr = '0;
        b_re = 1'b0; b_raddr = '0;
        ts_push = 1'b0; ts_push_byte = '0;
        tm_push = 1'b0; tm_push_byte = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    res_next        = '0;
                    flush_pend_next = 1'b0;
                    lf_pend_next    = 1'b0;
                    fl_idx_next     = '0;
                    wr_pend_next    = 1'b0;
                    echo_idx_next   = '0;
                    echo_char_next  = cmd.byte_in;
                    echo_kind_next  = ECHO_SINGLE;
                    echo_last_next  = echo_last(ECHO_SINGLE);
                    state_next      = S_DONE;
                    case (cmd.op)
                        OP_MASTER_WRITE:
                        begin
                            if (raw_reg)
                            begin
                                ts_push      = 1'b1;
                                ts_push_byte = cmd.byte_in;
                            end
                            else if (cmd.byte_in inside {CHAR_CR, CHAR_LF})
                            begin
                                echo_kind_next  = ECHO_CRLF;
                                echo_last_next  = echo_last(ECHO_CRLF);
                                flush_pend_next = 1'b1;
                                lf_pend_next    = 1'b1;
                                state_next      = S_ECHO;
                            end
                            else if (cmd.byte_in inside {CHAR_DEL, CHAR_BS})
                            begin
                                if (line_len_reg != '0)
                                begin
                                    line_len_next  = line_len_reg - 1'b1;
                                    echo_kind_next = ECHO_ERASE;
                                    echo_last_next = echo_last(ECHO_ERASE);
                                    state_next     = S_ECHO;
                                end
                            end
                            else if (cmd.byte_in == CHAR_ETX)
                            begin
                                intr_next      = 1'b1;
                                line_len_next  = '0;
                                echo_kind_next = ECHO_INTR;
                                echo_last_next = echo_last(ECHO_INTR);
                                state_next     = S_ECHO;
                            end
                            else if (cmd.byte_in == CHAR_EOT)
                            begin
                                eof_next   = 1'b1;
                                state_next = S_FLUSH;
                            end
                            else
                            begin
                                // A full line still echoes the byte but does not keep it.
                                if (line_len_reg < DEPTH_CNT)
                                begin
                                    a_we          = 1'b1;
                                    a_waddr       = {1'b1, line_len_reg[PTR_W-1:0]};
                                    a_wdata       = cmd.byte_in;
                                    line_len_next = line_len_reg + 1'b1;
                                end
                                state_next = S_ECHO;
                            end
                        end
                        OP_SLAVE_WRITE:
                        begin
                            if (cmd.byte_in == CHAR_LF)
                            begin
                                echo_kind_next = ECHO_CRLF;
                                echo_last_next = echo_last(ECHO_CRLF);
                            end
                            state_next = S_ECHO;
                        end
                        OP_MASTER_READ:
                        begin
                            if (tm_count_reg != '0)
                            begin
                                b_re                = 1'b1;
                                b_raddr             = tm_tail_reg;
                                tm_tail_next        = ptr_inc(tm_tail_reg);
                                tm_count_next       = tm_count_reg - 1'b1;
                                res_next.read_valid = 1'b1;
                                rd_sel_next         = 1'b0;
                                state_next          = S_RDWAIT;
                            end
                        end
                        OP_SLAVE_READ:
                        begin
                            if (ts_count_reg != '0)
                            begin
                                a_re                = 1'b1;
                                a_raddr             = {1'b0, ts_tail_reg};
                                ts_tail_next        = ptr_inc(ts_tail_reg);
                                ts_count_next       = ts_count_reg - 1'b1;
                                res_next.read_valid = 1'b1;
                                rd_sel_next         = 1'b1;
                                state_next          = S_RDWAIT;
                            end
                            else if (eof_reg)
                            begin
                                eof_next             = 1'b0;
                                res_next.end_of_file = 1'b1;
                            end
                        end
                        OP_TAKE_INTR:
                        begin
                            res_next.interrupt_pending = intr_reg;
                            intr_next                  = 1'b0;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_ECHO:
            begin
                tm_push      = 1'b1;
                tm_push_byte = echo_byte(echo_kind_reg, echo_idx_reg, echo_char_reg);
                if (echo_idx_reg == echo_last_reg)
                begin
                    state_next = flush_pend_reg ? S_FLUSH : S_DONE;
                end
                else
                begin
                    echo_idx_next = echo_idx_reg + 1'b1;
                end
            end
            S_FLUSH:
            begin
                // Line reads are registered in a_rdata_reg ahead of the ring writes they feed.
                if (fl_idx_reg != line_len_reg)
                begin
                    a_re        = 1'b1;
                    a_raddr     = {1'b1, fl_idx_reg[PTR_W-1:0]};
                    fl_idx_next = fl_idx_reg + 1'b1;
                end
                wr_pend_next = (fl_idx_reg != line_len_reg);
                if (wr_pend_reg)
                begin
                    ts_push      = 1'b1;
                    ts_push_byte = a_rdata_reg;
                end
                if (fl_idx_reg == line_len_reg && !wr_pend_reg)
                begin
                    line_len_next = '0;
                    state_next    = lf_pend_reg ? S_LF : S_DONE;
                end
            end
            S_LF:
            begin
                ts_push      = 1'b1;
                ts_push_byte = CHAR_LF;
                state_next   = S_DONE;
            end
            S_RDWAIT:
            begin
                res_next.byte_out = rd_sel_reg ? a_rdata_reg : b_rdata_reg;
                state_next        = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || rsp_ready)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Bytes pushed into a full ring are dropped one by one.
        if (ts_push && ts_count_reg < DEPTH_CNT)
        begin
            a_we          = 1'b1;
            a_waddr       = {1'b0, ts_head_reg};
            a_wdata       = ts_push_byte;
            ts_head_next  = ptr_inc(ts_head_reg);
            ts_count_next = ts_count_reg + 1'b1;
        end

        b_we    = 1'b0;
        b_waddr = tm_head_reg;
        b_wdata = tm_push_byte;
        if (tm_push && tm_count_reg < DEPTH_CNT)
        begin
            b_we          = 1'b1;
            tm_head_next  = ptr_inc(tm_head_reg);
            tm_count_next = tm_count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_we)
        begin
            mem_a[a_waddr] <= a_wdata;
        end
        if (a_re)
        begin
            a_rdata_reg <= mem_a[a_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_we)
        begin
            mem_b[b_waddr] <= b_wdata;
        end
        if (b_re)
        begin
            b_rdata_reg <= mem_b[b_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            ts_head_reg    <= '0;
            ts_tail_reg    <= '0;
            ts_count_reg   <= '0;
            tm_head_reg    <= '0;
            tm_tail_reg    <= '0;
            tm_count_reg   <= '0;
            line_len_reg   <= '0;
            fl_idx_reg     <= '0;
            wr_pend_reg    <= 1'b0;
            flush_pend_reg <= 1'b0;
            lf_pend_reg    <= 1'b0;
            intr_reg       <= 1'b0;
            eof_reg        <= 1'b0;
            raw_reg        <= 1'b0;
            rd_sel_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
            echo_idx_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            ts_head_reg    <= ts_head_next;
            ts_tail_reg    <= ts_tail_next;
            ts_count_reg   <= ts_count_next;
            tm_head_reg    <= tm_head_next;
            tm_tail_reg    <= tm_tail_next;
            tm_count_reg   <= tm_count_next;
            line_len_reg   <= line_len_next;
            fl_idx_reg     <= fl_idx_next;
            wr_pend_reg    <= wr_pend_next;
            flush_pend_reg <= flush_pend_next;
            lf_pend_reg    <= lf_pend_next;
            intr_reg       <= intr_next;
            eof_reg        <= eof_next;
            raw_reg        <= raw_next;
            rd_sel_reg     <= rd_sel_next;
            out_valid_reg  <= out_valid_next;
            echo_idx_reg   <= echo_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        echo_kind_reg <= echo_kind_next;
        echo_last_reg <= echo_last_next;
        echo_char_reg <= echo_char_next;
        res_reg       <= res_next;
        out_reg       <= out_next;
    end

endmodule

`default_nettype wire

### rtl/tld_checker.sv
// Port-level checks for the terminal line discipline, bound to its top level.
`timescale 1ns / 1ps
`default_nettype none

module tld_checker (
    input wire logic          clk,
    input wire logic          rst_n,
    input wire logic          rsp_valid,
    input wire logic          rsp_ready,
    input wire tld_pkg::rsp_t rsp,
    input wire logic          pready
);
    import tld_pkg::*;

    // A result waiting for the consumer must not change or vanish.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("result changed before its transfer");

    // Only a read that popped a byte may show a nonzero byte.
    a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.read_valid |-> rsp.byte_out == 8'h00)
        else $error("byte_out nonzero without read_valid");

    a_eof_empty: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.end_of_file |-> !rsp.read_valid)
        else $error("end_of_file reported with a popped byte");

    a_intr_alone: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.interrupt_pending |-> !rsp.read_valid && !rsp.end_of_file)
        else $error("interrupt reported together with read status");

    a_pready_high: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("pready dropped");

endmodule

bind terminal_line_discipline tld_checker u_tld_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .pready    (pready)
);

`default_nettype wire
